// ===== hw/rtl/bump_cliff_avoid_controller_unit_macros.svh =====
// Assertion macros for the bump/cliff avoid controller.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BUMP_CLIFF_AVOID_CONTROLLER_UNIT_MACROS_SVH
`define BUMP_CLIFF_AVOID_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BCAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcac check failed");
`define BCAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcac check failed");
`else
`define BCAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bcac_pkg.sv =====
// Shared types and constants for the bump/cliff avoid controller.
// No dependencies.
package bcac_pkg;

  localparam int CMD_FIFO_DEPTH_DEF = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_RADIUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIFF_BACKUP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUMP_BACKUP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PACKETS  = 3'd6;

  localparam logic [15:0] FORWARD_SPEED_RST = 16'd90;
  localparam logic [15:0] REVERSE_SPEED_RST = 16'hFF6A;
  localparam logic [15:0] TURN_SPEED_RST    = 16'd100;
  localparam logic [15:0] TURN_RADIUS_RST   = 16'hFFFF;
  localparam logic [7:0]  CLIFF_BACKUP_RST  = 8'd50;
  localparam logic [7:0]  BUMP_BACKUP_RST   = 8'd25;
  localparam logic [7:0]  TURN_PACKETS_RST  = 8'd50;

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_SYNC2  = 4'd1;
  localparam logic [3:0] PH_BUMPER = 4'd4;
  localparam logic [3:0] PH_CLIFF  = 4'd6;
  localparam logic [3:0] PH_BUTTON = 4'd13;

  localparam logic [7:0] SYNC1_BYTE   = 8'd1;
  localparam logic [7:0] SYNC2_BYTE   = 8'd15;
  localparam logic [7:0] BUTTON_STOP  = 8'd1;
  localparam logic [7:0] CLIFF_MAX    = 8'd11;
  localparam logic [7:0] BUMPER_MAX   = 8'd10;

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] HDR2 = 8'h06;
  localparam logic [7:0] HDR3 = 8'h01;
  localparam logic [7:0] HDR4 = 8'h04;
  localparam logic [3:0] DRIVE_LAST_IDX = 4'd9;

  typedef struct packed {
    logic        shutdown;
    logic [15:0] speed;
    logic [15:0] radius;
  } cmd_t;

endpackage

// ===== hw/rtl/bcac_ifs.sv =====
// Valid/ready channel interfaces for the bump/cliff avoid controller.
// Depends on bcac_pkg for the configuration index width.
interface bcac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bcac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic       shutdown;
  modport source (output valid, output tx_byte, output last_byte, output shutdown,
                  input ready);
  modport sink (input valid, input tx_byte, input last_byte, input shutdown,
                output ready);
endinterface

interface bcac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bcac_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bcac_front.sv =====
// Front end: configuration registers, sensor packet parser and motion sequencer.
// Depends on bcac_pkg and bcac_ifs; pushes drive/shutdown commands to the queue.
module bcac_front (
  input  logic            clk,
  input  logic            rst_n,
  bcac_in_if.sink         in_ch,
  bcac_cfg_if.sink        cfg_ch,
  input  logic            q_full,
  output logic            cmd_push,
  output bcac_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    MODE_DECIDE = 3'b001,
    MODE_BACKUP = 3'b010,
    MODE_TURN   = 3'b100
  } mode_t;

  logic [15:0] fwd_speed_r, rev_speed_r, turn_speed_r, turn_radius_r;
  logic [7:0]  cliff_backup_r, bump_backup_r, turn_pkts_r;

  logic [3:0] phase_r, phase_nxt;
  logic [7:0] bumper_r, bumper_nxt;
  logic [7:0] cliff_r, cliff_nxt;
  mode_t      mode_r, mode_nxt;
  logic [7:0] left_r, left_nxt;
  logic       halted_r, halted_nxt;

  logic       accept;
  logic [7:0] b;
  logic [7:0] left_dec;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && !q_full;
  assign b            = in_ch.rx_byte;
  assign left_dec     = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_speed_r    <= bcac_pkg::FORWARD_SPEED_RST;
      rev_speed_r    <= bcac_pkg::REVERSE_SPEED_RST;
      turn_speed_r   <= bcac_pkg::TURN_SPEED_RST;
      turn_radius_r  <= bcac_pkg::TURN_RADIUS_RST;
      cliff_backup_r <= bcac_pkg::CLIFF_BACKUP_RST;
      bump_backup_r  <= bcac_pkg::BUMP_BACKUP_RST;
      turn_pkts_r    <= bcac_pkg::TURN_PACKETS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bcac_pkg::REG_FORWARD_SPEED: fwd_speed_r    <= cfg_ch.data;
        bcac_pkg::REG_REVERSE_SPEED: rev_speed_r    <= cfg_ch.data;
        bcac_pkg::REG_TURN_SPEED:    turn_speed_r   <= cfg_ch.data;
        bcac_pkg::REG_TURN_RADIUS:   turn_radius_r  <= cfg_ch.data;
        bcac_pkg::REG_CLIFF_BACKUP:  cliff_backup_r <= cfg_ch.data[7:0];
        bcac_pkg::REG_BUMP_BACKUP:   bump_backup_r  <= cfg_ch.data[7:0];
        bcac_pkg::REG_TURN_PACKETS:  turn_pkts_r    <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    bumper_nxt = bumper_r;
    cliff_nxt  = cliff_r;
    mode_nxt   = mode_r;
    left_nxt   = left_r;
    halted_nxt = halted_r;
    cmd_push   = 1'b0;
    cmd        = '{shutdown: 1'b0, speed: fwd_speed_r, radius: 16'd0};
    if (accept && !halted_r) begin
      if (phase_r == bcac_pkg::PH_HUNT) begin
        if (b == bcac_pkg::SYNC1_BYTE) phase_nxt = bcac_pkg::PH_SYNC2;
      end else if (phase_r == bcac_pkg::PH_SYNC2) begin
        phase_nxt = (b == bcac_pkg::SYNC2_BYTE) ? bcac_pkg::PH_SYNC2 + 4'd1
                                                : bcac_pkg::PH_HUNT;
      end else if (phase_r < bcac_pkg::PH_BUTTON) begin
        if (phase_r == bcac_pkg::PH_BUMPER) bumper_nxt = b;
        if (phase_r == bcac_pkg::PH_CLIFF)  cliff_nxt  = b;
        phase_nxt = phase_r + 4'd1;
      end else begin
        phase_nxt = bcac_pkg::PH_HUNT;
        if (b == bcac_pkg::BUTTON_STOP) begin
          halted_nxt   = 1'b1;
          cmd_push     = 1'b1;
          cmd.shutdown = 1'b1;
        end else begin
          unique case (mode_r)
            MODE_BACKUP: begin
              if (left_dec == 8'd0) begin
                left_nxt   = turn_pkts_r;
                mode_nxt   = (turn_pkts_r == 8'd0) ? MODE_DECIDE : MODE_TURN;
                cmd_push   = 1'b1;
                cmd.speed  = turn_speed_r;
                cmd.radius = turn_radius_r;
              end else begin
                left_nxt = left_dec;
              end
            end
            MODE_TURN: begin
              left_nxt = left_dec;
              if (left_dec == 8'd0) mode_nxt = MODE_DECIDE;
            end
            default: begin
              cmd_push = 1'b1;
              if (cliff_r != 8'd0 && cliff_r <= bcac_pkg::CLIFF_MAX) begin
                left_nxt  = cliff_backup_r;
                mode_nxt  = MODE_BACKUP;
                cmd.speed = rev_speed_r;
              end else if (bumper_r != 8'd0 && bumper_r <= bcac_pkg::BUMPER_MAX) begin
                left_nxt  = bump_backup_r;
                mode_nxt  = MODE_BACKUP;
                cmd.speed = rev_speed_r;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bcac_pkg::PH_HUNT;
      bumper_r <= 8'd0;
      cliff_r  <= 8'd0;
      mode_r   <= MODE_DECIDE;
      left_r   <= 8'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bumper_r <= bumper_nxt;
      cliff_r  <= cliff_nxt;
      mode_r   <= mode_nxt;
      left_r   <= left_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== hw/rtl/bcac_cmd_fifo.sv =====
// Short command queue between the parser front end and the byte serializer.
// Depends on bcac_pkg for the command type.
module bcac_cmd_fifo #(
  parameter int DEPTH = bcac_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bcac_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bcac_pkg::cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bcac_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/bcac_back.sv =====
// Back end: expands queued commands into drive packet bytes or a shutdown item.
// Depends on bcac_pkg and bcac_ifs; drives the registered output channel.
module bcac_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  bcac_pkg::cmd_t head_cmd,
  output logic           pop,
  bcac_out_if.source     out_ch
);

  logic [3:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, shut_r;
  logic       advance, is_last;
  logic [7:0] next_byte, csum;

  assign csum = bcac_pkg::HDR2 ^ bcac_pkg::HDR3 ^ bcac_pkg::HDR4
              ^ head_cmd.speed[7:0] ^ head_cmd.speed[15:8]
              ^ head_cmd.radius[7:0] ^ head_cmd.radius[15:8];

  always_comb begin
    unique case (idx_r)
      4'd0:    next_byte = bcac_pkg::HDR0;
      4'd1:    next_byte = bcac_pkg::HDR1;
      4'd2:    next_byte = bcac_pkg::HDR2;
      4'd3:    next_byte = bcac_pkg::HDR3;
      4'd4:    next_byte = bcac_pkg::HDR4;
      4'd5:    next_byte = head_cmd.speed[7:0];
      4'd6:    next_byte = head_cmd.speed[15:8];
      4'd7:    next_byte = head_cmd.radius[7:0];
      4'd8:    next_byte = head_cmd.radius[15:8];
      4'd9:    next_byte = csum;
      default: next_byte = 8'd0;
    endcase
  end

  assign advance = head_valid && (!valid_r || out_ch.ready);
  assign is_last = head_cmd.shutdown || (idx_r == bcac_pkg::DRIVE_LAST_IDX);
  assign pop     = advance && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 4'd0;
      valid_r <= 1'b0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 4'd0 : idx_r + 4'd1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= head_cmd.shutdown ? 8'd0 : next_byte;
      last_r <= is_last;
      shut_r <= head_cmd.shutdown;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.tx_byte   = byte_r;
  assign out_ch.last_byte = last_r;
  assign out_ch.shutdown  = shut_r;

endmodule

// ===== hw/rtl/bump_cliff_avoid_controller_unit.sv =====
// Bump/cliff avoid controller: takes sensor stream bytes and returns drive
// packet bytes. A sensor byte is taken whenever the command queue has room;
// each drive packet leaves the output port at one byte per cycle while out_ch
// is ready, a shutdown item as a single byte, paced by the byte serializer.
// The input stalls only when CMD_FIFO_DEPTH commands wait to be serialized.
// Depends on bcac_pkg, bcac_ifs, bcac_front, bcac_cmd_fifo, bcac_back and the
// assertion macro header.
`include "bump_cliff_avoid_controller_unit_macros.svh"
module bump_cliff_avoid_controller_unit #(
  parameter int CMD_FIFO_DEPTH = bcac_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bcac_in_if.sink     in_ch,
  bcac_out_if.source  out_ch,
  bcac_cfg_if.sink    cfg_ch
);

  logic           cmd_push, q_full, q_pop, q_valid;
  bcac_pkg::cmd_t cmd, q_head;

  bcac_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  bcac_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  bcac_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  `BCAC_ASSERT_IMP(a_no_push_full, clk, rst_n, cmd_push, !q_full)
  `BCAC_ASSERT_IMP(a_shutdown_item, clk, rst_n, out_ch.valid && out_ch.shutdown, out_ch.last_byte && out_ch.tx_byte == 8'd0)
  `BCAC_ASSERT_NXT(a_quiet_after_stop, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.shutdown, !out_ch.valid && !q_valid)

endmodule
